>>> rtl/core/self_quotient_pixel_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the self-quotient pixel filter
// Clocked on clk_i, with checks off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SELF_QUOTIENT_PIXEL_FILTER_ASSERT_SVH
`define SELF_QUOTIENT_PIXEL_FILTER_ASSERT_SVH

// plain property check
`define SQPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sqpf assertion failed");

// implication check: antecedent then consequent
`define SQPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sqpf implication failed");

`endif

>>> rtl/core/sqpf_pkg.sv
// ----------------------------------------------------------------------------
// sqpf_pkg
// Shared widths, codes and types of the self-quotient pixel filter.
// ----------------------------------------------------------------------------
package sqpf_pkg;

  localparam int PIX_W         = 8;
  localparam int WIN_N         = 9;
  localparam int OUT_FRAC_BITS = 8;
  localparam int W_W           = 16;
  localparam int SUM_W         = 12;            // 9 * 255
  localparam int K_W           = W_W + 4;       // 9 weights
  localparam int NW_W          = W_W + PIX_W;   // one pixel * weight
  localparam int N_W           = NW_W + 4;      // 9 products
  localparam int DEN_W         = N_W + 4;       // 10*n + 9*k
  localparam int QUO_W         = 15;
  localparam int C90_W         = 15;            // center * 90
  localparam int NUM_W         = C90_W + K_W + OUT_FRAC_BITS;
  localparam int REM_W         = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
  localparam int DIV_STAGES    = QUO_W + 1;
  localparam int LATENCY       = 4 + DIV_STAGES;
  localparam int ADDR_W        = 4;

  localparam logic [QUO_W-1:0] QUO_MAX = '1;

  // register indexes
  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_EDGE   = 2'd1;
  localparam logic [1:0] REG_CORNER = 2'd2;

  // squared distance classes
  localparam logic [1:0] DIST_CTR = 2'd0;
  localparam logic [1:0] DIST_EDG = 2'd1;
  localparam logic [1:0] DIST_COR = 2'd2;

  localparam logic [W_W-1:0] RST_W_CTR = 16'd65535;
  localparam logic [W_W-1:0] RST_W_EDG = 16'd14624;
  localparam logic [W_W-1:0] RST_W_COR = 16'd3263;

  typedef struct packed {
    logic [W_W-1:0] w_ctr;
    logic [W_W-1:0] w_edg;
    logic [W_W-1:0] w_cor;
  } weights_t;

endpackage

>>> rtl/core/sqpf_lane.sv
// ----------------------------------------------------------------------------
// sqpf_lane
// One window position: mean test, weight pick and pixel * weight product.
// ----------------------------------------------------------------------------
module sqpf_lane (
  input  logic                          clk_i,
  input  logic [sqpf_pkg::PIX_W-1:0]    pix_i,
  input  logic [sqpf_pkg::SUM_W-1:0]    sum_i,
  input  logic [1:0]                    dist_i,
  input  sqpf_pkg::weights_t            weights_i,
  output logic [sqpf_pkg::W_W-1:0]      kw_o,
  output logic [sqpf_pkg::NW_W-1:0]     nw_o
);

  logic [sqpf_pkg::SUM_W-1:0] pix9;
  logic                       keep;
  logic [sqpf_pkg::W_W-1:0]   w_sel;
  logic [sqpf_pkg::W_W-1:0]   kw_d, kw_q;
  logic [sqpf_pkg::NW_W-1:0]  nw_d, nw_q;

  // 9*pix >= sum means at or above the mean
  assign pix9 = (sqpf_pkg::SUM_W'(pix_i) << 3) + sqpf_pkg::SUM_W'(pix_i);
  assign keep = (pix9 >= sum_i);

  always_comb begin
    unique case (dist_i)
      sqpf_pkg::DIST_CTR: w_sel = weights_i.w_ctr;
      sqpf_pkg::DIST_EDG: w_sel = weights_i.w_edg;
      default:            w_sel = weights_i.w_cor;
    endcase
  end

  assign kw_d = keep ? w_sel : '0;
  assign nw_d = sqpf_pkg::NW_W'(pix_i) * sqpf_pkg::NW_W'(kw_d);

  always_ff @(posedge clk_i) begin
    kw_q <= kw_d;
    nw_q <= nw_d;
  end

  assign kw_o = kw_q;
  assign nw_o = nw_q;

endmodule

>>> rtl/core/sqpf_merge.sv
// ----------------------------------------------------------------------------
// sqpf_merge
// Sums the lane results, then forms dividend and divisor.
// ----------------------------------------------------------------------------
module sqpf_merge (
  input  logic                                      clk_i,
  input  logic [sqpf_pkg::WIN_N-1:0][sqpf_pkg::W_W-1:0]  kw_i,
  input  logic [sqpf_pkg::WIN_N-1:0][sqpf_pkg::NW_W-1:0] nw_i,
  input  logic [sqpf_pkg::PIX_W-1:0]                center_i,
  output logic [sqpf_pkg::NUM_W-1:0]                num_o,
  output logic [sqpf_pkg::DEN_W-1:0]                den_o
);

  logic [sqpf_pkg::K_W-1:0]   k_d, k_q;
  logic [sqpf_pkg::N_W-1:0]   n_d, n_q;
  logic [sqpf_pkg::PIX_W-1:0] ctr_q;
  logic [sqpf_pkg::C90_W-1:0] c90;
  logic [sqpf_pkg::NUM_W-1:0] num_d, num_q;
  logic [sqpf_pkg::DEN_W-1:0] den_d, den_q;

  // add up the lanes
  always_comb begin
    k_d = '0;
    n_d = '0;
    for (int i = 0; i < sqpf_pkg::WIN_N; i++) begin
      k_d = k_d + sqpf_pkg::K_W'(kw_i[i]);
      n_d = n_d + sqpf_pkg::N_W'(nw_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    n_q   <= n_d;
    ctr_q <= center_i;
  end

  // num = c*90*k*2^frac, den = 10*n + 9*k
  assign c90   = sqpf_pkg::C90_W'(ctr_q) * sqpf_pkg::C90_W'(90);
  assign num_d = (sqpf_pkg::NUM_W'(c90) * sqpf_pkg::NUM_W'(k_q)) << sqpf_pkg::OUT_FRAC_BITS;
  assign den_d = (sqpf_pkg::DEN_W'(n_q) << 3) + (sqpf_pkg::DEN_W'(n_q) << 1)
               + (sqpf_pkg::DEN_W'(k_q) << 3) + sqpf_pkg::DEN_W'(k_q);

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
  end

  assign num_o = num_q;
  assign den_o = den_q;

endmodule

>>> rtl/core/sqpf_div.sv
// ----------------------------------------------------------------------------
// sqpf_div
// Pipelined restoring divider: an overflow stage, then one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module sqpf_div (
  input  logic                         clk_i,
  input  logic [sqpf_pkg::NUM_W-1:0]   num_i,
  input  logic [sqpf_pkg::DEN_W-1:0]   den_i,
  output logic [sqpf_pkg::QUO_W-1:0]   quo_o
);

  localparam int NS = sqpf_pkg::DIV_STAGES;

  logic [sqpf_pkg::REM_W-1:0] rem_in [NS];
  logic [sqpf_pkg::DEN_W-1:0] den_in [NS];
  logic [sqpf_pkg::QUO_W-1:0] quo_in [NS];
  logic                       sat_in [NS];
  logic                       zro_in [NS];

  logic [sqpf_pkg::REM_W-1:0] rem_q [NS];
  logic [sqpf_pkg::DEN_W-1:0] den_q [NS];
  logic [sqpf_pkg::QUO_W-1:0] quo_q [NS];
  logic                       sat_q [NS];
  logic                       zro_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int Sh = sqpf_pkg::QUO_W - s;
    logic [sqpf_pkg::REM_W-1:0] trial;
    logic                       ge;

    if (s == 0) begin : g_first
      assign rem_in[s] = sqpf_pkg::REM_W'(num_i);
      assign den_in[s] = den_i;
      assign quo_in[s] = '0;
      assign sat_in[s] = 1'b0;
      assign zro_in[s] = (den_i == '0);
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign den_in[s] = den_q[s-1];
      assign quo_in[s] = quo_q[s-1];
      assign sat_in[s] = sat_q[s-1];
      assign zro_in[s] = zro_q[s-1];
    end

    assign trial = sqpf_pkg::REM_W'(den_in[s]) << Sh;
    assign ge    = (rem_in[s] >= trial);

    // first stage detects overflow, the rest each settle one bit
    if (s == 0) begin : g_sat
      always_ff @(posedge clk_i) begin
        rem_q[s] <= rem_in[s];
        quo_q[s] <= quo_in[s];
        sat_q[s] <= ge;
      end
    end else begin : g_bit
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? (rem_in[s] - trial) : rem_in[s];
        quo_q[s] <= quo_in[s] | (sqpf_pkg::QUO_W'(ge) << Sh);
        sat_q[s] <= sat_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s] <= den_in[s];
      zro_q[s] <= zro_in[s];
    end
  end

  // zero divisor gives 0, overflow gives full scale
  assign quo_o = zro_q[NS-1] ? '0 : (sat_q[NS-1] ? sqpf_pkg::QUO_MAX : quo_q[NS-1]);

endmodule

>>> rtl/core/self_quotient_pixel_filter.sv
// ----------------------------------------------------------------------------
// self_quotient_pixel_filter
// 3x3 self-quotient filter: center / (weighted mean / 9 + 0.1), Q7.8.
// ----------------------------------------------------------------------------
// Takes one window per clock: busy stays low and a transaction is accepted on
// every cycle with start high. Each result appears on quotient_o with done_o
// high for one cycle, in order, once the window has passed the input register,
// the nine lane multipliers, two merge stages and a 16-stage divider pipeline
// (one overflow stage, one stage per quotient bit); the receiver cannot stall
// and must take it then. The weight registers must be written over APB only
// while no transaction is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module self_quotient_pixel_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [sqpf_pkg::PIX_W-1:0]        pix_nw_i,
  input  logic [sqpf_pkg::PIX_W-1:0]        pix_n_i,
  input  logic [sqpf_pkg::PIX_W-1:0]        pix_ne_i,
  input  logic [sqpf_pkg::PIX_W-1:0]        pix_w_i,
  input  logic [sqpf_pkg::PIX_W-1:0]        pix_c_i,
  input  logic [sqpf_pkg::PIX_W-1:0]        pix_e_i,
  input  logic [sqpf_pkg::PIX_W-1:0]        pix_sw_i,
  input  logic [sqpf_pkg::PIX_W-1:0]        pix_s_i,
  input  logic [sqpf_pkg::PIX_W-1:0]        pix_se_i,
  output logic                              done_o,
  output logic [sqpf_pkg::QUO_W-1:0]        quotient_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sqpf_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int LAT = sqpf_pkg::LATENCY;

  sqpf_pkg::weights_t weights_q, weights_d;
  logic               wr_en;
  logic [1:0]         reg_idx;

  logic [sqpf_pkg::WIN_N-1:0][sqpf_pkg::PIX_W-1:0]  pix_d, pix_q;
  logic [sqpf_pkg::SUM_W-1:0]                       sum_d, sum_q;
  logic [sqpf_pkg::PIX_W-1:0]                       ctr_q;
  logic [sqpf_pkg::WIN_N-1:0][sqpf_pkg::W_W-1:0]    kw;
  logic [sqpf_pkg::WIN_N-1:0][sqpf_pkg::NW_W-1:0]   nw;
  logic [sqpf_pkg::NUM_W-1:0]                       num;
  logic [sqpf_pkg::DEN_W-1:0]                       den;
  logic [LAT-1:0]                                   vld_d, vld_q;

  // APB register file
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    weights_d = weights_q;
    if (wr_en) begin
      unique case (reg_idx)
        sqpf_pkg::REG_CENTER: weights_d.w_ctr = pwdata[sqpf_pkg::W_W-1:0];
        sqpf_pkg::REG_EDGE:   weights_d.w_edg = pwdata[sqpf_pkg::W_W-1:0];
        sqpf_pkg::REG_CORNER: weights_d.w_cor = pwdata[sqpf_pkg::W_W-1:0];
        default:              weights_d = weights_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q.w_ctr <= sqpf_pkg::RST_W_CTR;
      weights_q.w_edg <= sqpf_pkg::RST_W_EDG;
      weights_q.w_cor <= sqpf_pkg::RST_W_COR;
    end else begin
      weights_q <= weights_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      sqpf_pkg::REG_CENTER: prdata = 32'(weights_q.w_ctr);
      sqpf_pkg::REG_EDGE:   prdata = 32'(weights_q.w_edg);
      sqpf_pkg::REG_CORNER: prdata = 32'(weights_q.w_cor);
      default:              prdata = '0;
    endcase
  end

  // input stage: window and its sum
  assign busy  = 1'b0;
  assign pix_d = {pix_se_i, pix_s_i, pix_sw_i, pix_e_i, pix_c_i,
                  pix_w_i, pix_ne_i, pix_n_i, pix_nw_i};

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < sqpf_pkg::WIN_N; i++) begin
      sum_d = sum_d + sqpf_pkg::SUM_W'(pix_d[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    sum_q <= sum_d;
    ctr_q <= pix_q[4];
  end

  // lanes, row order: corner edge corner / edge center edge / corner edge corner
  for (genvar i = 0; i < sqpf_pkg::WIN_N; i++) begin : g_lane
    localparam logic [1:0] Dist = (i == 4) ? sqpf_pkg::DIST_CTR :
                                  ((i % 2) == 1) ? sqpf_pkg::DIST_EDG : sqpf_pkg::DIST_COR;
    sqpf_lane u_lane (
      .clk_i     (clk_i),
      .pix_i     (pix_q[i]),
      .sum_i     (sum_q),
      .dist_i    (Dist),
      .weights_i (weights_q),
      .kw_o      (kw[i]),
      .nw_o      (nw[i])
    );
  end

  sqpf_merge u_merge (
    .clk_i    (clk_i),
    .kw_i     (kw),
    .nw_i     (nw),
    .center_i (ctr_q),
    .num_o    (num),
    .den_o    (den)
  );

  sqpf_div u_div (
    .clk_i (clk_i),
    .num_i (num),
    .den_i (den),
    .quo_o (quotient_o)
  );

  // valid tracking along the pipeline
  assign vld_d = {vld_q[LAT-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[LAT-1];

endmodule

>>> rtl/core/sqpf_checker.sv
// ----------------------------------------------------------------------------
// sqpf_checker
// Port-level checks of the self-quotient pixel filter, bound to the top.
// ----------------------------------------------------------------------------
`include "self_quotient_pixel_filter_assert.svh"

module sqpf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [sqpf_pkg::PIX_W-1:0]   pix_c_i,
  input logic                         done_o,
  input logic [sqpf_pkg::QUO_W-1:0]   quotient_o,
  input logic                         pready
);

  // each accepted transaction gives a result on done_o
  `SQPF_ASSERT_IMP(a_result_follows, start && !busy, ##20 done_o)
  // no result without a transaction
  `SQPF_ASSERT_IMP(a_no_spurious, done_o, $past(start, 20))
  // a zero center always gives zero
  `SQPF_ASSERT_IMP(a_zero_center, start && !busy && pix_c_i == '0, ##20 quotient_o == '0)
  // never stalls
  `SQPF_ASSERT(a_never_busy, !busy && pready)

endmodule

bind self_quotient_pixel_filter sqpf_checker u_sqpf_checker (.*);

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Self-quotient pixel filter testbench
// A directed table of windows runs first, then random windows under several
// weight settings written over APB between phases. Each quotient is typed in
// the directed table or predicted from the window and the current weights,
// and each done_o strobe is checked in order against the oldest pending one.
// ----------------------------------------------------------------------------
module testbench;
  import sqpf_pkg::*;

  localparam int PERIOD = 20;

  typedef logic [PIX_W-1:0] window_t [WIN_N];

  // one directed row: window in row order (nw first), optional typed quotient
  typedef struct packed {
    logic [WIN_N*PIX_W-1:0] win;
    bit                     typed;
    logic [QUO_W-1:0]       q;
  } dir_row_t;

  localparam int N_DIR = 16;
  localparam dir_row_t DIR_TABLE [N_DIR] = '{
    '{72'h00_00_00_00_00_00_00_00_00, 1'b1, 15'd0},     // all dark, zero center
    '{72'hFF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b1, 15'd2295},  // flat bright window
    '{72'h00_00_00_00_FF_00_00_00_00, 1'b1, 15'd2295},  // lone bright center
    '{72'h00_00_00_00_01_00_00_00_00, 1'b1, 15'd1212},  // lone dim center
    '{72'hFF_FF_FF_FF_00_FF_FF_FF_FF, 1'b1, 15'd0},     // dark center
    '{72'hFF_00_FF_00_00_00_FF_00_FF, 1'b1, 15'd0},     // corners only
    '{72'h00_FF_00_FF_FF_FF_00_FF_00, 1'b0, 15'd0},     // plus shape
    '{72'h55_AA_55_AA_55_AA_55_AA_55, 1'b0, 15'd0},
    '{72'hAA_55_AA_55_AA_55_AA_55_AA, 1'b0, 15'd0},
    '{72'h01_02_03_04_05_06_07_08_09, 1'b0, 15'd0},     // ramp
    '{72'h01_02_04_08_10_20_40_80_FF, 1'b0, 15'd0},     // walking bits
    '{72'h00_20_00_00_FF_00_00_00_00, 1'b0, 15'd0},     // bright center, one dim edge
    '{72'h00_00_00_00_FF_00_00_00_20, 1'b0, 15'd0},
    '{72'h80_80_80_80_80_80_80_80_7F, 1'b0, 15'd0},     // one pixel under mean
    '{72'h7F_7F_7F_7F_80_7F_7F_7F_7F, 1'b0, 15'd0},
    '{72'hFE_FD_FB_F7_EF_DF_BF_7F_FF, 1'b0, 15'd0}
  };

  logic              clk_i, rst_ni;
  logic              start, busy;
  logic [PIX_W-1:0]  pix_nw_i, pix_n_i, pix_ne_i, pix_w_i, pix_c_i;
  logic [PIX_W-1:0]  pix_e_i, pix_sw_i, pix_s_i, pix_se_i;
  logic              done_o;
  logic [QUO_W-1:0]  quotient_o;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;

  // weights as the filter should hold them
  logic [W_W-1:0] w_ctr_q, w_edg_q, w_cor_q;

  logic [QUO_W-1:0] pending_quot[$];
  int unsigned      n_errors;
  int unsigned      n_sent;

  self_quotient_pixel_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pix_nw_i   (pix_nw_i),
    .pix_n_i    (pix_n_i),
    .pix_ne_i   (pix_ne_i),
    .pix_w_i    (pix_w_i),
    .pix_c_i    (pix_c_i),
    .pix_e_i    (pix_e_i),
    .pix_sw_i   (pix_sw_i),
    .pix_s_i    (pix_s_i),
    .pix_se_i   (pix_se_i),
    .done_o     (done_o),
    .quotient_o (quotient_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(PERIOD/2) clk_i = ~clk_i;
  end

  // run limit: far above the slowest correct run
  initial begin
    #(PERIOD * 400000);
    $display("** self_quotient_pixel_filter: FAILED **");
    $finish;
  end

  // quotient = center*90*K*2^8 / (10*N + 9*K), truncated and saturated
  function automatic logic [QUO_W-1:0] quot_predict(input window_t px);
    logic [63:0]    sum, k, n, num, den, q, w;
    logic [1:0]     cls;
    sum = 0;
    k   = 0;
    n   = 0;
    for (int i = 0; i < WIN_N; i++) sum += px[i];
    for (int i = 0; i < WIN_N; i++) begin
      if (64'(WIN_N) * px[i] >= sum) begin
        cls = (i == 4) ? DIST_CTR : (i % 2 == 1) ? DIST_EDG : DIST_COR;
        case (cls)
          DIST_CTR: w = w_ctr_q;
          DIST_EDG: w = w_edg_q;
          default:  w = w_cor_q;
        endcase
        k += w;
        n += px[i] * w;
      end
    end
    den = 10 * n + 9 * k;
    num = (64'(px[4]) * 90 * k) << OUT_FRAC_BITS;
    if (den == 0) return '0;
    q = num / den;
    return (q > 64'(QUO_MAX)) ? QUO_MAX : q[QUO_W-1:0];
  endfunction

  // random window: mostly structured, some plain noise
  function automatic window_t rand_window();
    window_t     px;
    int unsigned mode, base;
    mode = $urandom_range(0, 9);
    base = $urandom_range(0, 255);
    for (int i = 0; i < WIN_N; i++) begin
      case (mode)
        4, 5, 6: px[i] = 8'(base + $urandom_range(0, 6) - 3);    // near flat
        7:       px[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        8:       px[i] = (i == 4) ? 8'($urandom_range(128, 255))
                                  : 8'($urandom_range(0, 40));
        9:       px[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        default: px[i] = 8'($urandom);
      endcase
    end
    return px;
  endfunction

  // one transaction: idle cycles at random, then hold start until accepted
  task automatic push_window(input window_t px, input bit typed,
                             input logic [QUO_W-1:0] typed_q, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(0, 99) < 25) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start    <= 1'b1;
    pix_nw_i <= px[0];
    pix_n_i  <= px[1];
    pix_ne_i <= px[2];
    pix_w_i  <= px[3];
    pix_c_i  <= px[4];
    pix_e_i  <= px[5];
    pix_sw_i <= px[6];
    pix_s_i  <= px[7];
    pix_se_i <= px[8];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_quot.insert(pending_quot.size(), typed ? typed_q : quot_predict(px));
    n_sent++;
  endtask

  // drain all pending results before touching the weights
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_quot.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // APB write, setup then access; upper data bits are junk on purpose
  task automatic reg_write(input logic [1:0] idx, input logic [W_W-1:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_CENTER: w_ctr_q = val;
      REG_EDGE:   w_edg_q = val;
      REG_CORNER: w_cor_q = val;
      default: ;
    endcase
    if (idx <= REG_CORNER) begin
      // read back
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      rd = prdata;
      if (rd[W_W-1:0] !== val) begin
        $error("weight readback: expected %0d, actual %0d", val, rd[W_W-1:0]);
        n_errors++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_weights(input logic [W_W-1:0] c, e, r);
    wait_idle();
    reg_write(REG_CENTER, c);
    reg_write(REG_EDGE, e);
    reg_write(REG_CORNER, r);
  endtask

  // random phase; a stretch of items runs back to back with no idling
  task automatic random_phase(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_idle();
      push_window(rand_window(), 1'b0, '0, !(n_sent >= 300 && n_sent < 450));
    end
  endtask

  // result checker: done_o can't be stalled, so take it every strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_quot.size() == 0) begin
        $error("quotient: unexpected result %0d", quotient_o);
        n_errors++;
      end else begin
        logic [QUO_W-1:0] exp_q;
        exp_q = pending_quot.pop_front();
        if (quotient_o !== exp_q) begin
          $error("quotient: expected %0d, actual %0d", exp_q, quotient_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    window_t px;
    int      guard;
    n_errors = 0;
    n_sent   = 0;
    rst_ni   = 1'b0;
    start    = 1'b0;
    {pix_nw_i, pix_n_i, pix_ne_i, pix_w_i, pix_c_i} = '0;
    {pix_e_i, pix_sw_i, pix_s_i, pix_se_i} = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    w_ctr_q = RST_W_CTR;
    w_edg_q = RST_W_EDG;
    w_cor_q = RST_W_COR;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset weights
    foreach (DIR_TABLE[r]) begin
      for (int i = 0; i < WIN_N; i++)
        px[i] = DIR_TABLE[r].win[PIX_W*(WIN_N-1-i) +: PIX_W];
      push_window(px, DIR_TABLE[r].typed, DIR_TABLE[r].q, 1'b1);
    end
    random_phase(100);

    // writes past the last register must be ignored
    wait_idle();
    reg_write(2'd3, 16'($urandom));
    random_phase(60);

    set_weights(16'd1, 16'd1, 16'd1);
    random_phase(120);
    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(120);
    set_weights(16'd0, 16'd0, 16'd0);        // zero weights give zero
    random_phase(60);
    set_weights(16'd0, 16'hFFFF, 16'hFFFF);  // center weight off
    random_phase(100);
    set_weights(16'hFFFF, 16'd1, 16'd0);
    random_phase(100);
    set_weights(16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(100);
    set_weights(RST_W_CTR, RST_W_EDG, RST_W_COR);
    random_phase(60);

    // drain
    start <= 1'b0;
    guard = 0;
    while (pending_quot.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk_i);
    if (n_errors == 0 && pending_quot.size() == 0) begin
      $display("** self_quotient_pixel_filter: PASSED **");
    end else begin
      if (pending_quot.size() != 0)
        $error("quotient: %0d results never arrived", pending_quot.size());
      $display("** self_quotient_pixel_filter: FAILED **");
    end
    $finish;
  end

endmodule
